### src/esfp_pkg.sv
`timescale 1ns / 1ps

package esfp_pkg;

    // Parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_COLOR  = 5'b00010,
        PH_SCOUNT = 5'b00100,
        PH_STITCH = 5'b01000,
        PH_DRAIN  = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_COLOR  = 3'd1,
        KIND_COUNT  = 3'd2,
        KIND_STITCH = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STOP   = 2'd1,
        MODE_TRIM   = 2'd2
    } t_mode;

    // Byte positions inside header, color entry and stitch record
    localparam logic [3:0] HDR_VERSION = 4'd0;
    localparam logic [3:0] HDR_HOOP    = 4'd1;
    localparam logic [3:0] HDR_CNT_LO  = 4'd2;
    localparam logic [3:0] COL_RED     = 4'd0;
    localparam logic [3:0] COL_GREEN   = 4'd1;
    localparam logic [3:0] COL_BLUE    = 4'd2;
    localparam logic [3:0] CNT_LO      = 4'd0;
    localparam logic [3:0] ST_X0       = 4'd1;
    localparam logic [3:0] ST_X1       = 4'd2;
    localparam logic [3:0] ST_X2       = 4'd3;
    localparam logic [3:0] ST_Y0       = 4'd5;
    localparam logic [3:0] ST_Y1       = 4'd6;
    localparam logic [3:0] ST_Y2       = 4'd7;
    localparam logic [3:0] ST_FLAGS    = 4'd8;

    localparam int FLAG_STOP_BIT = 0;
    localparam int FLAG_TRIM_BIT = 2;

    localparam int TDATA_W = 112;
    localparam int TUSER_W = 3;
    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_kind              record_kind;
        logic [7:0]         version;
        logic [7:0]         hoop_size;
        logic [15:0]        item_count;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [23:0] x_pos;
        logic signed [23:0] y_pos;
        t_mode              stitch_mode;
        logic               colors_all_zero;
        logic               last;
    } t_rec;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
        t_rec a;
        t_rec b;
    } t_push;

endpackage

### src/esfp_in_reg.sv
`timescale 1ns / 1ps

module esfp_in_reg
    import esfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_ready,
    input  logic       i_take,
    output t_in_item   o_item
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_eoi;

    // free when empty or when the held byte is consumed this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data_byte <= i_data_byte;
            r_eoi       <= i_end_of_input;
        end
    end

    assign o_item = '{valid: r_valid, data_byte: r_data_byte, end_of_input: r_eoi};

endmodule

### src/esfp_parser.sv
`timescale 1ns / 1ps

module esfp_parser
    import esfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  logic     i_room,
    output logic     o_fire,
    output t_push    o_push
);

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_bir,     n_bir;
    logic [15:0] r_items,   n_items;
    logic [7:0]  r_cnt_lo,  n_cnt_lo;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_hoop,    n_hoop;
    logic [15:0] r_color,   n_color;
    logic [23:0] r_x,       n_x;
    logic [15:0] r_y,       n_y;
    logic        r_all_zero, n_all_zero;

    logic [7:0]  b;
    logic [15:0] cnt;
    logic [15:0] items_dec;
    t_rec        rec_a, rec_b, end_rec;
    logic        have_a, have_b;

    assign o_fire    = i_item.valid && i_room;
    assign b         = i_item.data_byte;
    assign cnt       = {b, r_cnt_lo};
    assign items_dec = r_items - 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_bir      = r_bir;
        n_items    = r_items;
        n_cnt_lo   = r_cnt_lo;
        n_version  = r_version;
        n_hoop     = r_hoop;
        n_color    = r_color;
        n_x        = r_x;
        n_y        = r_y;
        n_all_zero = r_all_zero;
        rec_a      = '0;
        rec_b      = '0;
        end_rec    = '0;
        end_rec.record_kind = KIND_END;
        have_a     = 1'b0;
        have_b     = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                case (r_bir)
                    HDR_VERSION: begin
                        n_version = b;
                        n_bir     = 4'd1;
                    end
                    HDR_HOOP: begin
                        n_hoop = b;
                        n_bir  = 4'd2;
                    end
                    HDR_CNT_LO: begin
                        n_cnt_lo = b;
                        n_bir    = 4'd3;
                    end
                    default: begin
                        have_a            = 1'b1;
                        rec_a.record_kind = KIND_HEADER;
                        rec_a.version     = r_version;
                        rec_a.hoop_size   = r_hoop;
                        rec_a.item_count  = cnt;
                        n_items           = cnt;
                        n_bir             = 4'd0;
                        n_phase           = (cnt != 16'd0) ? PH_COLOR : PH_SCOUNT;
                    end
                endcase
            end
            PH_COLOR: begin
                case (r_bir)
                    COL_RED: begin
                        n_color = {8'd0, b};
                        n_bir   = 4'd1;
                    end
                    COL_GREEN: begin
                        n_color = {b, r_color[7:0]};
                        n_bir   = 4'd2;
                    end
                    COL_BLUE: begin
                        have_a            = 1'b1;
                        rec_a.record_kind = KIND_COLOR;
                        rec_a.red         = r_color[7:0];
                        rec_a.green       = r_color[15:8];
                        rec_a.blue        = b;
                        if (r_color != 16'd0 || b != 8'd0) begin
                            n_all_zero = 1'b0;
                        end
                        n_bir = 4'd3;
                    end
                    default: begin
                        // pad byte closes the entry
                        n_items = items_dec;
                        n_bir   = 4'd0;
                        if (items_dec == 16'd0) begin
                            n_phase = PH_SCOUNT;
                        end
                    end
                endcase
            end
            PH_SCOUNT: begin
                if (r_bir == CNT_LO) begin
                    n_cnt_lo = b;
                    n_bir    = 4'd1;
                end else begin
                    have_a                = 1'b1;
                    rec_a.record_kind     = KIND_COUNT;
                    rec_a.item_count      = cnt;
                    rec_a.colors_all_zero = r_all_zero;
                    n_items               = cnt;
                    n_bir                 = 4'd0;
                    if (cnt == 16'd0) begin
                        have_b  = 1'b1;
                        rec_b   = end_rec;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_STITCH;
                    end
                end
            end
            PH_STITCH: begin
                case (r_bir)
                    ST_X0:   n_x      = {16'd0, b};
                    ST_X1:   n_x      = {8'd0, b, r_x[7:0]};
                    ST_X2:   n_x      = {b, r_x[15:0]};
                    ST_Y0:   n_y      = {8'd0, b};
                    ST_Y1:   n_y      = {b, r_y[7:0]};
                    ST_Y2:   n_cnt_lo = b;
                    default: ;
                endcase
                if (r_bir < ST_FLAGS) begin
                    n_bir = r_bir + 4'd1;
                end else begin
                    have_a            = 1'b1;
                    rec_a.record_kind = KIND_STITCH;
                    rec_a.x_pos       = r_x;
                    rec_a.y_pos       = {r_cnt_lo, r_y};
                    if (b[FLAG_STOP_BIT]) begin
                        rec_a.stitch_mode = MODE_STOP;
                    end else if (b[FLAG_TRIM_BIT]) begin
                        rec_a.stitch_mode = MODE_TRIM;
                    end else begin
                        rec_a.stitch_mode = MODE_NORMAL;
                    end
                    n_items = items_dec;
                    n_bir   = 4'd0;
                    if (items_dec == 16'd0) begin
                        have_b  = 1'b1;
                        rec_b   = end_rec;
                        n_phase = PH_DRAIN;
                    end
                end
            end
            default: ;
        endcase

        if (i_item.end_of_input) begin
            // truncated file: close it with an end record
            if (n_phase != PH_DRAIN) begin
                if (have_a) begin
                    have_b = 1'b1;
                    rec_b  = end_rec;
                end else begin
                    have_a = 1'b1;
                    rec_a  = end_rec;
                end
            end
            n_phase    = PH_HEADER;
            n_bir      = 4'd0;
            n_items    = 16'd0;
            n_cnt_lo   = 8'd0;
            n_version  = 8'd0;
            n_hoop     = 8'd0;
            n_color    = 16'd0;
            n_x        = 24'd0;
            n_y        = 16'd0;
            n_all_zero = 1'b1;
        end

        rec_a.last = !have_b;
        rec_b.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_bir      <= 4'd0;
            r_items    <= 16'd0;
            r_cnt_lo   <= 8'd0;
            r_version  <= 8'd0;
            r_hoop     <= 8'd0;
            r_color    <= 16'd0;
            r_x        <= 24'd0;
            r_y        <= 16'd0;
            r_all_zero <= 1'b1;
        end else if (o_fire) begin
            r_phase    <= n_phase;
            r_bir      <= n_bir;
            r_items    <= n_items;
            r_cnt_lo   <= n_cnt_lo;
            r_version  <= n_version;
            r_hoop     <= n_hoop;
            r_color    <= n_color;
            r_x        <= n_x;
            r_y        <= n_y;
            r_all_zero <= n_all_zero;
        end
    end

    assign o_push = '{a_valid: o_fire && have_a, b_valid: o_fire && have_b,
                      a: rec_a, b: rec_b};

endmodule

### src/esfp_out_queue.sv
`timescale 1ns / 1ps

module esfp_out_queue
    import esfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rec  o_rec
);

    t_rec       r_slot [QUEUE_DEPTH];
    t_rec       n_slot [QUEUE_DEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] cnt_after;
    logic       pop;

    assign o_valid   = (r_cnt != 2'd0);
    assign o_rec     = r_slot[0];
    assign pop       = o_valid && i_ready;
    // two free slots guaranteed whatever the sink does this cycle
    assign o_room    = (r_cnt <= 2'd1);
    assign cnt_after = r_cnt - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (i_push.a_valid && cnt_after == 2'(i)) begin
                n_slot[i] = i_push.a;
            end
            if (i_push.b_valid && cnt_after + 2'd1 == 2'(i)) begin
                n_slot[i] = i_push.b;
            end
        end
        n_cnt = cnt_after + {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

endmodule

### src/embroidery_stitch_file_parser_top.sv
`timescale 1ns / 1ps

// Byte-stream parser for PCD/PCS style stitch files. Feed the file one byte per
// transfer on the slave side, with tlast on its final byte. The master side
// carries one record per transfer: a header (version, hoop code, color count),
// one thread color per palette entry, a stitch count with an all-black flag,
// one record per stitch (signed 24-bit X/Y in tenths of a millimetre plus a
// normal/stop/trim mode), and an end record after the last stitch, after a zero
// stitch count or on a truncated file. After the end record, bytes are dropped
// until tlast, and the next byte starts a new file. tlast on the master side
// marks the final record caused by one input byte. A byte waits in the input
// register until the parser takes it, and its records are registered into a
// three-entry output queue whose head drives the master side. The slave side
// takes one byte per cycle while the sink keeps up; a byte that yields two
// records (count plus end, last stitch plus end, or a truncation) holds off the
// next byte until the single-record-per-cycle output port drains the queue.
module embroidery_stitch_file_parser_top
    import esfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] data_byte
    input  logic               i_s_tlast,   // end_of_input
    // master side
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // version, hoop_size, item_count, red,
                                            // green, blue, x_pos, y_pos,
                                            // stitch_mode, colors_all_zero, 5'b0
    output logic [TUSER_W-1:0] o_m_tuser,   // record_kind
    output logic               o_m_tlast    // last record for this byte
);

    t_in_item w_item;
    t_push    w_push;
    t_rec     w_rec;
    logic     w_room;
    logic     w_fire;

    // Input register: holds one byte until the parser can take it
    esfp_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_data_byte    (i_s_tdata),
        .i_end_of_input (i_s_tlast),
        .o_ready        (o_s_tready),
        .i_take         (w_fire),
        .o_item         (w_item)
    );

    // Parser: advance the file state and build up to two records per byte
    esfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_room  (w_room),
        .o_fire  (w_fire),
        .o_push  (w_push)
    );

    // Output queue: registers records and parts parser from the sink
    esfp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rec   (w_rec)
    );

    assign o_m_tdata = {5'd0, w_rec.colors_all_zero, w_rec.stitch_mode, w_rec.y_pos,
                        w_rec.x_pos, w_rec.blue, w_rec.green, w_rec.red,
                        w_rec.item_count, w_rec.hoop_size, w_rec.version};
    assign o_m_tuser = w_rec.record_kind;
    assign o_m_tlast = w_rec.last;

`ifndef NO_ASSERTIONS
    // a second record never goes out without a first one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.b_valid |-> w_push.a_valid)
        else $error("second record pushed without first");

    // records are produced only from a held byte with queue room
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.a_valid || w_push.b_valid) |-> (w_item.valid && w_room))
        else $error("record pushed without a byte or without room");

    // an end record always closes the records of its byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_END) |-> o_m_tlast)
        else $error("end record not marked last");

    // hold a stalled record unchanged until the sink takes it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
                                         $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled record changed");
`endif

endmodule
